/* rtl/i2cee_pkg.sv */
// ----------------------------------------------------------------------------
// i2cee_pkg
// Types, constants and sequencer helper functions for the I2C EEPROM byte
// master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
    localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd1;
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd2;

    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd10;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd200;
    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;

    localparam int unsigned BITS_PER_BYTE = 8;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // bus operations of a transaction program
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_DEVW  = 3'd1,
        OP_ADDR  = 3'd2,
        OP_DATA  = 3'd3,
        OP_DEVR  = 3'd4,
        OP_READ  = 3'd5,
        OP_STOP  = 3'd6,
        OP_END   = 3'd7
    } op_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_poll_limit;
        logic [6:0]  device_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack;
    } tick_out_t;

    typedef struct packed {
        logic        active;
        logic        is_read;
        logic [2:0]  op_pos;
        logic [2:0]  step;
        logic [15:0] phase_count;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [7:0]  poll_count;
        logic [7:0]  held_address;
        logic [7:0]  held_data;
        logic [7:0]  received_byte;
        logic        nack_flag;
        logic        scl_level;
        logic        sda_level;
    } seq_t;

    localparam seq_t SEQ_RESET = '{
        active:        1'b0,
        is_read:       1'b0,
        op_pos:        3'd0,
        step:          3'd0,
        phase_count:   16'd0,
        bit_count:     4'd0,
        shift_byte:    8'd0,
        poll_count:    8'd0,
        held_address:  8'd0,
        held_data:     8'd0,
        received_byte: 8'd0,
        nack_flag:     1'b0,
        scl_level:     1'b1,
        sda_level:     1'b1
    };

    function automatic op_t prog_op(input logic is_read, input logic [2:0] pos);
        op_t op;
        op = OP_END;
        if (is_read) begin
            case (pos)
                3'd0:    op = OP_START;
                3'd1:    op = OP_DEVW;
                3'd2:    op = OP_ADDR;
                3'd3:    op = OP_START;
                3'd4:    op = OP_DEVR;
                3'd5:    op = OP_READ;
                3'd6:    op = OP_STOP;
                default: op = OP_END;
            endcase
        end else begin
            case (pos)
                3'd0:    op = OP_START;
                3'd1:    op = OP_DEVW;
                3'd2:    op = OP_ADDR;
                3'd3:    op = OP_DATA;
                3'd4:    op = OP_STOP;
                default: op = OP_END;
            endcase
        end
        return op;
    endfunction

    // restart the phase timer and drive the line levels of the current step
    function automatic seq_t set_levels(input seq_t s);
        seq_t r;
        op_t  op;
        r  = s;
        op = prog_op(s.is_read, s.op_pos);
        r.phase_count = '0;
        case (op)
            OP_START: begin
                if (s.step == 3'd0)      r.sda_level = 1'b1;
                else if (s.step == 3'd1) r.scl_level = 1'b1;
                else if (s.step == 3'd2) r.sda_level = 1'b0;
                else                     r.scl_level = 1'b0;
            end
            OP_READ: begin
                if (s.step == 3'd0)      r.sda_level = 1'b1;
                else if (s.step == 3'd1) r.scl_level = 1'b1;
                else if (s.step == 3'd4) r.scl_level = 1'b0;
            end
            OP_STOP: begin
                if (s.step == 3'd0)      r.sda_level = 1'b0;
                else if (s.step == 3'd1) r.scl_level = 1'b1;
                else                     r.sda_level = 1'b1;
            end
            default: begin
                if (s.step == 3'd0)                          r.sda_level = s.shift_byte[7];
                else if (s.step == 3'd1 || s.step == 3'd4)   r.scl_level = 1'b1;
                else if (s.step == 3'd2 || s.step == 3'd5)   r.scl_level = 1'b0;
                else                                         r.sda_level = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic seq_t go_step(input seq_t s, input logic [2:0] step);
        seq_t r;
        r      = s;
        r.step = step;
        return set_levels(r);
    endfunction

    function automatic seq_t begin_op(input seq_t s, input logic [6:0] dev);
        seq_t r;
        op_t  op;
        r  = s;
        op = prog_op(s.is_read, s.op_pos);
        r.step       = '0;
        r.bit_count  = '0;
        r.poll_count = '0;
        if (op == OP_END) begin
            r.active = 1'b0;
        end else begin
            case (op)
                OP_DEVW: r.shift_byte = {dev, 1'b0};
                OP_DEVR: r.shift_byte = {dev, 1'b1};
                OP_ADDR: r.shift_byte = s.held_address;
                OP_DATA: r.shift_byte = s.held_data;
                OP_READ: r.shift_byte = '0;
                default: r.shift_byte = s.shift_byte;
            endcase
            r = set_levels(r);
        end
        return r;
    endfunction

    function automatic seq_t next_op(input seq_t s, input logic [6:0] dev);
        seq_t r;
        r        = s;
        r.op_pos = s.op_pos + 3'd1;
        return begin_op(r, dev);
    endfunction

    // last tick of a timed phase
    function automatic seq_t phase_done(input seq_t s, input logic sda,
                                        input logic [6:0] dev);
        seq_t r;
        op_t  op;
        r  = s;
        op = prog_op(s.is_read, s.op_pos);
        case (op)
            OP_START: begin
                if (s.step < 3'd3) r = go_step(r, s.step + 3'd1);
                else               r = next_op(r, dev);
            end
            OP_STOP: begin
                if (s.step < 3'd2) r = go_step(r, s.step + 3'd1);
                else               r.active = 1'b0;
            end
            OP_READ: begin
                if (s.step == 3'd2) r.shift_byte = {s.shift_byte[6:0], sda};
                if (s.step < 3'd4) begin
                    r = go_step(r, s.step + 3'd1);
                end else begin
                    r.bit_count = s.bit_count + 4'd1;
                    if (r.bit_count < 4'(BITS_PER_BYTE)) begin
                        r = go_step(r, 3'd1);
                    end else begin
                        r.received_byte = r.shift_byte;
                        r = next_op(r, dev);
                    end
                end
            end
            default: begin
                if (s.step == 3'd2) begin
                    r.shift_byte = {s.shift_byte[6:0], 1'b0};
                    r.bit_count  = s.bit_count + 4'd1;
                    r = go_step(r, (r.bit_count < 4'(BITS_PER_BYTE)) ? 3'd0 : 3'd3);
                end else if (s.step == 3'd5) begin
                    r = next_op(r, dev);
                end else begin
                    r = go_step(r, s.step + 3'd1);
                end
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/i2cee_core.sv */
// ----------------------------------------------------------------------------
// i2cee_core
// Bus sequencer: one tick per enable, with the tick result formed
// combinationally from the current state and the tick's inputs.
// ----------------------------------------------------------------------------
module i2cee_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  i2cee_pkg::cfg_t      cfg,
    input  i2cee_pkg::tick_in_t  tick_in,
    output i2cee_pkg::tick_out_t tick_out
);

    i2cee_pkg::seq_t seq_reg;
    i2cee_pkg::seq_t seq_start;
    i2cee_pkg::seq_t seq_next;
    logic            done_tick;

    // command launch: takes effect before the line levels of this tick show
    always_comb begin
        seq_start = seq_reg;
        if (!seq_reg.active && (tick_in.command == i2cee_pkg::CMD_WRITE ||
                                tick_in.command == i2cee_pkg::CMD_READ)) begin
            seq_start.is_read      = (tick_in.command == i2cee_pkg::CMD_READ);
            seq_start.held_address = tick_in.mem_address;
            seq_start.held_data    = tick_in.write_data;
            seq_start.nack_flag    = 1'b0;
            seq_start.op_pos       = '0;
            seq_start.active       = 1'b1;
            seq_start = i2cee_pkg::begin_op(seq_start, cfg.device_address);
        end
    end

    // next state
    always_comb begin : next_state
        i2cee_pkg::op_t op;
        logic [16:0]    period;
        seq_next  = seq_start;
        done_tick = 1'b0;
        op        = i2cee_pkg::prog_op(seq_start.is_read, seq_start.op_pos);
        period    = (cfg.phase_ticks == '0) ? 17'd1 : {1'b0, cfg.phase_ticks};
        if (seq_start.active) begin
            if (op != i2cee_pkg::OP_START && op != i2cee_pkg::OP_STOP &&
                op != i2cee_pkg::OP_READ && seq_start.step == 3'd4) begin
                // acknowledge poll with SCL high
                if (!tick_in.sda_in) begin
                    seq_next = i2cee_pkg::go_step(seq_start, 3'd5);
                end else if (seq_start.poll_count >= cfg.ack_poll_limit) begin
                    seq_next.nack_flag = 1'b1;
                    seq_next = i2cee_pkg::go_step(seq_next, 3'd5);
                end else begin
                    seq_next.poll_count = seq_start.poll_count + 8'd1;
                end
            end else if ({1'b0, seq_start.phase_count} + 17'd1 >= period) begin
                done_tick = (op == i2cee_pkg::OP_STOP) && (seq_start.step == 3'd2);
                seq_next  = i2cee_pkg::phase_done(seq_start, tick_in.sda_in,
                                                  cfg.device_address);
            end else begin
                seq_next.phase_count = seq_start.phase_count + 16'd1;
            end
        end
    end

    // outputs
    always_comb begin
        tick_out.scl       = seq_start.scl_level;
        tick_out.sda_out   = seq_start.sda_level;
        tick_out.busy_res  = seq_start.active;
        tick_out.done_res  = done_tick;
        tick_out.read_data = seq_next.received_byte;
        tick_out.nack      = seq_next.nack_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= i2cee_pkg::SEQ_RESET;
        end else if (tick_en) begin
            seq_reg <= seq_next;
        end
    end

endmodule

/* rtl/i2c_eeprom_byte_master.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Bit-level I2C master for single-byte EEPROM write and random read, one bus
// tick per stream transaction.
//
//   channel   dir   payload                                        handshake
//   s_        in    tuser: command; tdata: mem_address,            tvalid/tready
//                   write_data, sda_in
//   m_        out   tdata: scl, sda_out, busy_res, done_res,       tvalid/tready
//                   read_data, nack
//   cfg_      in    cfg_index, cfg_wdata                           cfg_wr_en
//
// One tick is accepted per clock unless the m_ side stalls; its result appears
// in the output register on the next cycle. The sequencer state and the output
// register sit on the same clock edge, so the rate is one tick per cycle.
// A stalled m_ side holds the result and drops s_tready until it is taken.
// Reset (synchronous, active low) releases both bus lines and restores the
// register defaults.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] command
    input  logic [23:0] s_tdata,    // [7:0] mem_address, [15:8] write_data, [16] sda_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] scl, [1] sda_out, [2] busy_res, [3] done_res,
                                    // [11:4] read_data, [12] nack
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    i2cee_pkg::cfg_t      cfg_reg;
    i2cee_pkg::tick_in_t  tick_in;
    i2cee_pkg::tick_out_t tick_out;
    logic                 accept;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks    <= i2cee_pkg::PHASE_TICKS_RESET;
            cfg_reg.ack_poll_limit <= i2cee_pkg::ACK_POLL_LIMIT_RESET;
            cfg_reg.device_address <= i2cee_pkg::DEVICE_ADDRESS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2cee_pkg::REG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg_wdata;
                i2cee_pkg::REG_ACK_POLL_LIMIT: cfg_reg.ack_poll_limit <= cfg_wdata[7:0];
                i2cee_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign tick_in.command     = s_tuser;
    assign tick_in.mem_address = s_tdata[7:0];
    assign tick_in.write_data  = s_tdata[15:8];
    assign tick_in.sda_in      = s_tdata[16];

    i2cee_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick_en  (accept),
        .cfg      (cfg_reg),
        .tick_in  (tick_in),
        .tick_out (tick_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload register: load on every accepted tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, tick_out.nack, tick_out.read_data,
                            tick_out.done_res, tick_out.busy_res,
                            tick_out.sda_out, tick_out.scl};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/i2cee_checker.sv */
// ----------------------------------------------------------------------------
// i2cee_checker
// Port-level checks for the I2C EEPROM byte master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an empty output register never stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // every accepted tick produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no result");

    // stop completion only inside a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("done without busy");

    // idle bus has both lines released
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
        else $error("bus lines not released while idle");

endmodule

bind i2c_eeprom_byte_master i2cee_checker u_i2cee_checker (.*);
